FILE: rtl/core/lzwd_pkg.sv
// Shared types and constants for the LZSS window decoder.
// No dependencies; every other file in the block imports this package.
package lzwd_pkg;

    localparam int          WindowDepth = 4096;
    localparam int          OffsetW     = 12;
    localparam int          MatchMin    = 3;
    localparam int          MatchMax    = 18;
    localparam logic [7:0]  SpaceByte   = 8'h20;
    localparam logic [7:0]  ZeroByte    = 8'h00;
    localparam logic [3:0]  FlagCount   = 4'd8;

    typedef logic [OffsetW-1:0] t_addr;

    typedef struct packed {
        logic       rd_en;
        t_addr      rd_addr;
        logic       wr_en;
        logic [7:0] wr_data;
        logic       clear;
    } t_win_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_emit;

endpackage

FILE: rtl/core/lzwd_window.sv
// Ring window memory with write pointer and fill count for the LZSS decoder.
// Depends on lzwd_pkg; entries not yet written read back as a space, or as zero from StartPos up.
module lzwd_window #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WindowDepth
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lzwd_pkg::t_win_req i_req,
    output logic [7:0]         o_rdata
);
    import lzwd_pkg::*;

    localparam int            AW       = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] StartPos = AW'(WINDOW_DEPTH - MatchMax);
    localparam logic [AW:0]   FillMax  = (AW+1)'(WINDOW_DEPTH);

    logic [7:0]    r_mem [WINDOW_DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW:0]   r_fill, n_fill;
    logic [7:0]    r_q, r_dflt;
    logic          r_written;
    logic [AW-1:0] rd_idx, rd_dist;
    logic          rd_written;

    assign rd_idx     = i_req.rd_addr[AW-1:0];
    assign rd_dist    = rd_idx - StartPos;
    assign rd_written = {1'b0, rd_dist} < r_fill;

    always_comb begin
        n_wp   = r_wp;
        n_fill = r_fill;
        if (i_req.clear) begin
            n_wp   = StartPos;
            n_fill = '0;
        end else if (i_req.wr_en) begin
            n_wp   = r_wp + 1'b1;
            n_fill = (r_fill == FillMax) ? r_fill : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= StartPos;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[r_wp] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q       <= r_mem[rd_idx];
            r_written <= rd_written;
            r_dflt    <= (rd_idx >= StartPos) ? ZeroByte : SpaceByte;
        end
    end

    assign o_rdata = r_written ? r_q : r_dflt;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.rd_en && i_req.wr_en))
        else $error("Window read and write issued in the same cycle.");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax)
        else $error("Window fill count exceeds the depth.");

    a_clear_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clear |=> (r_fill == '0) && (r_wp == StartPos))
        else $error("Window clear did not restore the pointer and fill count.");

endmodule

FILE: rtl/core/lzwd_ctrl.sv
// Token parser and copy sequencer for the LZSS decoder.
// Depends on lzwd_pkg; drives window reads through one address counter, while writes use the window's write pointer.
module lzwd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_in_byte,
    input  logic               i_block_last,
    input  logic               i_out_free,
    output lzwd_pkg::t_emit    o_emit,
    output lzwd_pkg::t_win_req o_req,
    input  logic [7:0]         i_rdata
);
    import lzwd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_PUT  = 3'b100
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_flags, n_flags;
    logic [3:0] r_bits_left, n_bits_left;
    logic       r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_addr      r_addr, n_addr;
    logic [4:0] r_left, n_left;
    logic       r_lit, n_lit;
    logic [7:0] r_lit_byte, n_lit_byte;
    logic       r_blk_last, n_blk_last;
    logic       accept;
    logic [7:0] put_byte;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign put_byte = r_lit ? r_lit_byte : i_rdata;

    always_comb begin
        n_state     = r_state;
        n_flags     = r_flags;
        n_bits_left = r_bits_left;
        n_phase     = r_phase;
        n_held      = r_held;
        n_addr      = r_addr;
        n_left      = r_left;
        n_lit       = r_lit;
        n_lit_byte  = r_lit_byte;
        n_blk_last  = r_blk_last;
        o_req       = '0;
        o_emit      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_blk_last = i_block_last;
                    if (r_bits_left == '0) begin
                        n_flags     = i_in_byte;
                        n_bits_left = FlagCount;
                        n_phase     = 1'b0;
                    end else if (!r_phase) begin
                        if (r_flags[0]) begin
                            n_lit       = 1'b1;
                            n_lit_byte  = i_in_byte;
                            n_left      = '0;
                            n_flags     = r_flags >> 1;
                            n_bits_left = r_bits_left - 1'b1;
                            n_state     = S_PUT;
                        end else begin
                            n_held  = i_in_byte;
                            n_phase = 1'b1;
                        end
                    end else begin
                        n_addr      = {i_in_byte[7:4], r_held};
                        n_left      = {1'b0, i_in_byte[3:0]} + 5'(MatchMin - 1);
                        n_lit       = 1'b0;
                        n_phase     = 1'b0;
                        n_flags     = r_flags >> 1;
                        n_bits_left = r_bits_left - 1'b1;
                        n_state     = S_READ;
                    end
                    if (i_block_last && (n_state == S_IDLE)) begin
                        n_flags     = '0;
                        n_bits_left = '0;
                        n_phase     = 1'b0;
                        n_held      = '0;
                        o_req.clear = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_addr;
                n_state       = S_PUT;
            end
            S_PUT: begin
                if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.data   = put_byte;
                    o_emit.last   = (r_left == '0);
                    o_req.wr_en   = 1'b1;
                    o_req.wr_data = put_byte;
                    if (r_left == '0) begin
                        n_state = S_IDLE;
                        if (r_blk_last) begin
                            n_flags     = '0;
                            n_bits_left = '0;
                            n_phase     = 1'b0;
                            n_held      = '0;
                            o_req.clear = 1'b1;
                        end
                    end else begin
                        n_left  = r_left - 1'b1;
                        n_addr  = r_addr + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_bits_left <= '0;
            r_phase     <= 1'b0;
            r_held      <= '0;
            r_blk_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flags     <= n_flags;
            r_bits_left <= n_bits_left;
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_blk_last  <= n_blk_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_lit      <= n_lit;
        r_lit_byte <= n_lit_byte;
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> i_out_free)
        else $error("A word was emitted while the output register was occupied.");

    a_read_then_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_PUT))
        else $error("A window read was not followed by its put cycle.");

    a_copy_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && !o_emit.last) |=> (r_state == S_READ))
        else $error("A copy stopped before its final byte.");

endmodule

FILE: rtl/core/lzwd_output_reg.sv
// Output register that holds one decoded word until the consumer takes it.
// Depends on lzwd_pkg for the emit structure.
module lzwd_output_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lzwd_pkg::t_emit i_emit,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);
    import lzwd_pkg::*;

    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_emit.valid) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_byte <= i_emit.data;
            r_last <= i_emit.last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;

endmodule

FILE: rtl/core/lzwd_window_decoder.sv
// LZSS decoder with a 4096-byte window takes one compressed byte per handshake
// and returns decoded words. A flag byte or the first byte of a reference
// yields nothing. A literal yields its own byte. Each byte of a reference
// copy needs a read of the single-port window and then its write-back, and
// an output stall holds the write-back together with the put. The window
// needs no clearing pass after reset or at a block end: a fill count marks
// which entries have been written since, and every other entry reads back
// as a space (or as zero in the top eighteen entries).
module lzss_window_decoder #(
    parameter int WINDOW_DEPTH = lzwd_pkg::WindowDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_block_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import lzwd_pkg::*;

    t_win_req   win_req;
    t_emit      emit;
    logic [7:0] win_rdata;
    logic       out_free;

    lzwd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_block_last(i_block_last),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_req       (win_req),
        .i_rdata     (win_rdata)
    );

    lzwd_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (win_req),
        .o_rdata(win_rdata)
    );

    lzwd_output_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_emit    (emit),
        .o_free    (out_free),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_byte(o_out_byte),
        .o_run_last(o_run_last)
    );

endmodule
